// File: sv/stns_pkg.sv
// ----------------------------------------------------------------------------
// stns_pkg
// shared constants, types and the sine table of the tone note sequencer
// ----------------------------------------------------------------------------
package stns_pkg;

  localparam int unsigned SEQ_DEPTH  = 1024;
  localparam int unsigned VALUE_BITS = 10;
  localparam int unsigned ADDR_W     = $clog2(SEQ_DEPTH);

  localparam int unsigned NOTE_W  = 11;
  localparam int unsigned CNT26_W = 26;
  localparam int unsigned TONE_W  = 16;
  localparam int unsigned CFG_W   = 26;
  localparam int unsigned IDX_W   = 3;

  // threshold arithmetic widths
  localparam int unsigned OPA_W  = 27;
  localparam int unsigned OPB_W  = 11;
  localparam int unsigned PROD_W = OPA_W + OPB_W;
  localparam int unsigned DVD_W  = 37;
  localparam int unsigned DEN_W  = 18;

  localparam int unsigned SINE_SIZE = 45;
  localparam int unsigned SINE_W    = $clog2(SINE_SIZE);
  localparam logic [SINE_W-1:0] SINE_LAST = SINE_W'(SINE_SIZE - 1);

  localparam logic [9:0] SINE_TABLE [SINE_SIZE] = '{
    10'd410, 10'd467, 10'd523, 10'd576, 10'd627, 10'd673, 10'd714, 10'd749, 10'd778,
    10'd799, 10'd813, 10'd819, 10'd817, 10'd807, 10'd789, 10'd764, 10'd732, 10'd694,
    10'd650, 10'd602, 10'd550, 10'd495, 10'd438, 10'd381, 10'd324, 10'd270, 10'd217,
    10'd169, 10'd125, 10'd87,  10'd55,  10'd30,  10'd12,  10'd2,   10'd0,   10'd6,
    10'd20,  10'd41,  10'd70,  10'd105, 10'd146, 10'd193, 10'd243, 10'd297, 10'd353
  };

  typedef enum logic [IDX_W-1:0] {
    REG_SEQ_MAX   = 3'd0,
    REG_SEQ_LEN   = 3'd1,
    REG_SCHED_PER = 3'd2,
    REG_TONE_MAX  = 3'd3,
    REG_TONE_MIN  = 3'd4,
    REG_LEN_MAX   = 3'd5,
    REG_LEN_MIN   = 3'd6,
    REG_LEN_DIV   = 3'd7
  } reg_idx_e;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_LOAD = 1'b1
  } opcode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL_HI,
    ST_MUL_DIFF,
    ST_MUL_DEN,
    ST_CHECK,
    ST_DIV
  } state_e;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DEN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

endpackage

// File: sv/stns_ram.sv
// ----------------------------------------------------------------------------
// stns_ram
// simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module stns_ram #(
  parameter int unsigned DEPTH  = 1024,
  parameter int unsigned DATA_W = 10
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DATA_W-1:0]        wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [DATA_W-1:0]        rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// File: sv/stns_div.sv
// ----------------------------------------------------------------------------
// stns_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module stns_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  stns_pkg::div_req_t req_i,
  output stns_pkg::div_rsp_t rsp_o
);
  import stns_pkg::*;

  localparam int unsigned CNT_W = $clog2(DVD_W + 1);

  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DVD_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [DEN_W:0]   trial;

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quo_q[DVD_W-1]};
    if (req_i.start) begin
      rem_d  = '0;
      quo_d  = req_i.dividend;
      den_d  = req_i.divisor;
      cnt_d  = CNT_W'(DVD_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = DEN_W'(trial - {1'b0, den_q});
        quo_d = {quo_q[DVD_W-2:0], 1'b1};
      end else begin
        rem_d = trial[DEN_W-1:0];
        quo_d = {quo_q[DVD_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

`ifndef SYNTHESIS
  a_done_ends_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("divider done while busy");
  a_start_sets_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |=> busy_q) else $error("divider did not start");
  a_count_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q != '0) else $error("divider count ran out while busy");
`endif

endmodule

// File: sv/sine_tone_note_sequencer.sv
// ----------------------------------------------------------------------------
// sine_tone_note_sequencer
// plays a stored sequence of values as sine tones on a dac
// ----------------------------------------------------------------------------
//  channel   dir  handshake                    payload
//  s_axis    in   s_axis_tvalid/s_axis_tready  tdata index,value  tuser opcode
//  m_axis    out  m_axis_tvalid/m_axis_tready  tdata dac value    tuser flags
//  cfg       in   cfg_we_i                     cfg_index_i, cfg_wdata_i
//
//  a load or a plain tick needs no threshold pass; a tick that starts a note
//  runs two threshold passes of three multiplies, a compare and, unless the
//  numerator is below the divisor, a 37-step division on the shared divider
//  the result register is loaded at accept; a new item is taken once it drains
//  and no threshold pass runs; no clearing pass: entries are undefined until loaded
// ----------------------------------------------------------------------------
module sine_tone_note_sequencer (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [stns_pkg::IDX_W-1:0]       cfg_index_i,
  input  logic [stns_pkg::CFG_W-1:0]       cfg_wdata_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [23:0]                      s_axis_tdata,  // entry_index, entry_value
  input  logic                             s_axis_tuser,  // opcode
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [15:0]                      m_axis_tdata,  // dac_value
  output logic [3:0]                       m_axis_tuser   // dac_write, note_started,
                                                          // note_sounding, sequence_done
);
  import stns_pkg::*;

  // configuration
  logic [9:0]         seq_max_q;
  logic [NOTE_W-1:0]  seq_len_q;
  logic [CNT26_W-1:0] sched_per_q;
  logic [TONE_W-1:0]  tone_max_q, tone_min_q;
  logic [CNT26_W-1:0] len_max_q, len_min_q;
  logic [7:0]         len_div_q;

  // playback state
  logic [NOTE_W-1:0]  next_note_q;
  logic [NOTE_W-1:0]  note_idx_q;
  logic [CNT26_W-1:0] sched_cnt_q;
  logic               sched_run_q;
  logic [TONE_W-1:0]  tone_cnt_q, tone_lim_q;
  logic               tone_run_q;
  logic [CNT26_W-1:0] len_cnt_q, len_lim_q;
  logic               len_run_q;
  logic [SINE_W-1:0]  sine_pos_q;

  state_e state_q, state_d;
  logic   pass_q;

  logic               m_valid_q;
  logic [9:0]         m_dac_q;
  logic [3:0]         m_user_q;

  logic               accept;
  logic               is_load;
  logic [9:0]         in_index;
  logic [9:0]         in_value;

  // tick results
  logic [NOTE_W-1:0]  t_next_note;
  logic [CNT26_W-1:0] t_sched_cnt;
  logic               t_sched_run;
  logic [TONE_W-1:0]  t_tone_cnt;
  logic               t_tone_run;
  logic [CNT26_W-1:0] t_len_cnt;
  logic               t_len_run;
  logic [SINE_W-1:0]  t_sine_pos;
  logic               t_dac_write;
  logic [9:0]         t_dac_value;
  logic               t_started;
  logic [NOTE_W-1:0]  play_len;

  // threshold datapath
  logic [VALUE_BITS-1:0]    ram_rdata;
  logic                     ram_re;
  logic                     ram_we;
  logic [CNT26_W-1:0]       sel_hi, sel_lo;
  logic [7:0]               sel_k;
  logic [9:0]               s_eff;
  logic signed [OPA_W-1:0]  op_a;
  logic signed [OPB_W-1:0]  op_b;
  logic signed [PROD_W-1:0] prod_q, a_q, num_q;
  logic [DEN_W-1:0]         den;
  logic                     num_small;
  logic [CNT26_W-1:0]       capped;
  div_req_t                 div_req;
  div_rsp_t                 div_rsp;
  logic                     lim_we;
  logic [CNT26_W-1:0]       lim_val;

  assign is_load  = (s_axis_tuser == OP_LOAD);
  assign in_index = s_axis_tdata[9:0];
  assign in_value = s_axis_tdata[19:10];

  assign s_axis_tready = (state_q == ST_IDLE) && (!m_valid_q || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_max_q   <= 10'd1;
      seq_len_q   <= 11'd1000;
      sched_per_q <= 26'd1250000;
      tone_max_q  <= 16'd5351;
      tone_min_q  <= 16'd1062;
      len_max_q   <= 26'd40000000;
      len_min_q   <= 26'd625000;
      len_div_q   <= 8'd5;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_SEQ_MAX:   seq_max_q   <= cfg_wdata_i[9:0];
        REG_SEQ_LEN:   seq_len_q   <= cfg_wdata_i[NOTE_W-1:0];
        REG_SCHED_PER: sched_per_q <= cfg_wdata_i;
        REG_TONE_MAX:  tone_max_q  <= cfg_wdata_i[TONE_W-1:0];
        REG_TONE_MIN:  tone_min_q  <= cfg_wdata_i[TONE_W-1:0];
        REG_LEN_MAX:   len_max_q   <= cfg_wdata_i;
        REG_LEN_MIN:   len_min_q   <= cfg_wdata_i;
        REG_LEN_DIV:   len_div_q   <= cfg_wdata_i[7:0];
        default:       ;
      endcase
    end
  end

  assign play_len = (seq_len_q > NOTE_W'(SEQ_DEPTH)) ? NOTE_W'(SEQ_DEPTH) : seq_len_q;

  // one timer tick: tone, then length, then scheduler
  always_comb begin
    t_next_note = next_note_q;
    t_sched_cnt = sched_cnt_q;
    t_sched_run = sched_run_q;
    t_tone_cnt  = tone_cnt_q;
    t_tone_run  = tone_run_q;
    t_len_cnt   = len_cnt_q;
    t_len_run   = len_run_q;
    t_sine_pos  = sine_pos_q;
    t_dac_write = 1'b0;
    t_dac_value = '0;
    t_started   = 1'b0;
    if (tone_run_q) begin
      t_tone_cnt = tone_cnt_q + TONE_W'(1);
      if (t_tone_cnt >= tone_lim_q) begin
        t_tone_cnt  = '0;
        t_sine_pos  = (sine_pos_q >= SINE_LAST) ? '0 : sine_pos_q + SINE_W'(1);
        t_dac_write = 1'b1;
        t_dac_value = SINE_TABLE[t_sine_pos];
      end
    end
    if (len_run_q) begin
      t_len_cnt = len_cnt_q + CNT26_W'(1);
      if (t_len_cnt >= len_lim_q) begin
        t_tone_run  = 1'b0;
        t_tone_cnt  = '0;
        t_len_run   = 1'b0;
        t_len_cnt   = '0;
        t_dac_write = 1'b1;
        t_dac_value = '0;
      end
    end
    if (sched_run_q) begin
      t_sched_cnt = sched_cnt_q + CNT26_W'(1);
      if (t_sched_cnt >= sched_per_q) begin
        t_sched_cnt = '0;
        if (next_note_q >= play_len) begin
          t_sched_run = 1'b0;
        end else if (!t_tone_run && !t_len_run) begin
          t_next_note = next_note_q + NOTE_W'(1);
          if (t_next_note >= play_len) begin
            t_sched_run = 1'b0;
          end
          t_tone_cnt = '0;
          t_tone_run = 1'b1;
          t_len_cnt  = '0;
          t_len_run  = 1'b1;
          t_started  = 1'b1;
        end
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && !is_load && t_started) begin
          state_d = ST_READ;
        end
      end
      ST_READ:     state_d = ST_MUL_HI;
      ST_MUL_HI:   state_d = ST_MUL_DIFF;
      ST_MUL_DIFF: state_d = ST_MUL_DEN;
      ST_MUL_DEN:  state_d = ST_CHECK;
      ST_CHECK: begin
        if (!num_small) begin
          state_d = ST_DIV;
        end else if (!pass_q) begin
          state_d = ST_MUL_HI;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          state_d = pass_q ? ST_IDLE : ST_MUL_HI;
        end
      end
      default:     state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    ram_re           = 1'b0;
    op_a             = '0;
    op_b             = '0;
    div_req.start    = 1'b0;
    div_req.dividend = num_q[DVD_W-1:0];
    div_req.divisor  = den;
    lim_we           = 1'b0;
    lim_val          = capped;
    case (state_q)
      ST_READ:     ram_re = 1'b1;
      ST_MUL_HI: begin
        op_a = signed'({1'b0, sel_hi});
        op_b = signed'({1'b0, s_eff});
      end
      ST_MUL_DIFF: begin
        op_a = signed'({1'b0, sel_hi}) - signed'({1'b0, sel_lo});
        op_b = signed'(OPB_W'(ram_rdata));
      end
      ST_MUL_DEN: begin
        op_a = signed'(OPA_W'(s_eff));
        op_b = signed'(OPB_W'(sel_k));
      end
      ST_CHECK: begin
        div_req.start = !num_small;
        lim_we        = num_small;
        lim_val       = CNT26_W'(1);
      end
      ST_DIV:      lim_we = div_rsp.done;
      default:     ;
    endcase
  end

  assign s_eff  = (seq_max_q == '0) ? 10'd1 : seq_max_q;
  assign sel_hi = pass_q ? len_max_q : CNT26_W'(tone_max_q);
  assign sel_lo = pass_q ? len_min_q : CNT26_W'(tone_min_q);
  assign sel_k  = !pass_q ? 8'd1 : ((len_div_q == '0) ? 8'd1 : len_div_q);

  assign den       = prod_q[DEN_W-1:0];
  assign num_small = num_q < signed'(PROD_W'(den));

  always_comb begin
    if (pass_q) begin
      capped = (div_rsp.quotient > DVD_W'({CNT26_W{1'b1}})) ? {CNT26_W{1'b1}}
                                                            : div_rsp.quotient[CNT26_W-1:0];
    end else begin
      capped = (div_rsp.quotient > DVD_W'({TONE_W{1'b1}})) ? CNT26_W'({TONE_W{1'b1}})
                                                           : CNT26_W'(div_rsp.quotient[TONE_W-1:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= op_a * op_b;
    if (state_q == ST_MUL_DIFF) begin
      a_q <= prod_q;
    end
    if (state_q == ST_MUL_DEN) begin
      num_q <= a_q - prod_q;
    end
  end

  stns_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign ram_we = accept && is_load && (32'(in_index) < SEQ_DEPTH);

  stns_ram #(
    .DEPTH  (SEQ_DEPTH),
    .DATA_W (VALUE_BITS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (in_index[ADDR_W-1:0]),
    .wdata_i (in_value[VALUE_BITS-1:0]),
    .re_i    (ram_re),
    .raddr_i (note_idx_q[ADDR_W-1:0]),
    .rdata_o (ram_rdata)
  );

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pass_q      <= 1'b0;
      next_note_q <= '0;
      note_idx_q  <= '0;
      sched_cnt_q <= '0;
      sched_run_q <= 1'b1;
      tone_cnt_q  <= '0;
      tone_lim_q  <= '0;
      tone_run_q  <= 1'b0;
      len_cnt_q   <= '0;
      len_lim_q   <= '0;
      len_run_q   <= 1'b0;
      sine_pos_q  <= SINE_LAST;
      m_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept && !is_load) begin
        next_note_q <= t_next_note;
        note_idx_q  <= next_note_q;
        sched_cnt_q <= t_sched_cnt;
        sched_run_q <= t_sched_run;
        tone_cnt_q  <= t_tone_cnt;
        tone_run_q  <= t_tone_run;
        len_cnt_q   <= t_len_cnt;
        len_run_q   <= t_len_run;
        sine_pos_q  <= t_sine_pos;
        pass_q      <= 1'b0;
      end
      if (lim_we) begin
        if (pass_q) begin
          len_lim_q <= lim_val;
        end else begin
          tone_lim_q <= lim_val[TONE_W-1:0];
          pass_q     <= 1'b1;
        end
      end
      if (accept) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (is_load) begin
        m_dac_q  <= '0;
        m_user_q <= {!sched_run_q, tone_run_q, 1'b0, 1'b0};
      end else begin
        m_dac_q  <= t_dac_value;
        m_user_q <= {!t_sched_run, t_tone_run, t_started, t_dac_write};
      end
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {6'b0, m_dac_q};
  assign m_axis_tuser  = m_user_q;

`ifndef SYNTHESIS
  a_tone_needs_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tone_run_q |-> len_run_q) else $error("tone running without length counter");
  a_start_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !is_load && t_started) |=> state_q != ST_IDLE)
    else $error("note start did not compute limits");
  a_limits_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && len_run_q) |-> (tone_lim_q != '0 && len_lim_q != '0))
    else $error("note running with zero limit");
  a_sine_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sine_pos_q <= SINE_LAST) else $error("sine position out of table");
`endif

endmodule

// File: dv/sine_tone_note_sequencer_tb.sv
// ----------------------------------------------------------------------------
// sine_tone_note_sequencer_tb
// streams load and tick items into the sequencer with random gaps and output
// stalls, predicts every dac item from its own copy of the counters and the
// sequence store, and compares each result field by field in order
// ----------------------------------------------------------------------------
module sine_tone_note_sequencer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import stns_pkg::*;

  localparam int unsigned QUIET_LIMIT = 3000;
  localparam int unsigned SETTLE_CYCLES = 100;
  localparam bit [25:0] MASK26 = 26'h3FFFFFF;

  typedef struct packed {
    logic       dac_write;
    logic [9:0] dac_value;
    logic       note_started;
    logic       note_sounding;
    logic       sequence_done;
  } dac_result_t;

  logic                 clk_i;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [IDX_W-1:0]     cfg_index_i = '0;
  logic [CFG_W-1:0]     cfg_wdata_i = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [23:0]          s_axis_tdata = '0;
  logic                 s_axis_tuser = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [15:0]          m_axis_tdata;
  logic [3:0]           m_axis_tuser;

  // predictor copy of the registers
  bit [9:0]  cfg_seq_max  = 10'd1;
  bit [10:0] cfg_seq_len  = 11'd1000;
  bit [25:0] cfg_period   = 26'd1250000;
  bit [15:0] cfg_tone_max = 16'd5351;
  bit [15:0] cfg_tone_min = 16'd1062;
  bit [25:0] cfg_len_max  = 26'd40000000;
  bit [25:0] cfg_len_min  = 26'd625000;
  bit [7:0]  cfg_len_div  = 8'd5;

  // predictor copy of the state
  bit [9:0]  seq_store [SEQ_DEPTH];
  bit        seq_written [SEQ_DEPTH];
  bit [10:0] next_idx  = '0;
  bit [25:0] sched_cnt = '0;
  bit        sched_on  = 1'b1;
  bit [15:0] tone_cnt  = '0;
  bit [15:0] tone_lim  = '0;
  bit        tone_on   = 1'b0;
  bit [25:0] len_cnt   = '0;
  bit [25:0] len_lim   = '0;
  bit        len_on    = 1'b0;
  bit [5:0]  sine_pos  = 6'd44;

  dac_result_t pending_dac_q [$];
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  int unsigned stall_left = 0;
  bit          idle_en = 1'b1;

  sine_tone_note_sequencer uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // floor((hi*smax - (hi-lo)*value) / (smax*k)), at least 1, at most cap
  function automatic bit [25:0] calc_limit(bit [25:0] hi, bit [25:0] lo, bit [9:0] value,
                                           bit [7:0] k, bit [25:0] cap);
    longint s;
    longint kk;
    longint num;
    longint den;
    longint t;
    s = (cfg_seq_max == 0) ? 1 : longint'(cfg_seq_max);
    kk = (k == 0) ? 1 : longint'(k);
    num = longint'(hi) * s - (longint'(hi) - longint'(lo)) * longint'(value);
    den = s * kk;
    if (num < den) return 26'd1;
    t = num / den;
    if (t > longint'(cap)) return cap;
    return t[25:0];
  endfunction

  function automatic dac_result_t tone_step(opcode_e op, bit [9:0] idx, bit [9:0] val);
    dac_result_t r;
    bit [10:0]   play_len;
    bit [9:0]    v;
    r = '0;
    if (op == OP_LOAD) begin
      seq_store[idx] = val;
      seq_written[idx] = 1'b1;
    end else begin
      if (tone_on) begin
        tone_cnt = tone_cnt + 16'd1;
        if (tone_cnt >= tone_lim) begin
          tone_cnt = '0;
          sine_pos = (sine_pos >= SINE_SIZE - 1) ? 6'd0 : sine_pos + 6'd1;
          r.dac_write = 1'b1;
          r.dac_value = SINE_TABLE[sine_pos];
        end
      end
      if (len_on) begin
        len_cnt = len_cnt + 26'd1;
        if (len_cnt >= len_lim) begin
          tone_on = 1'b0;
          tone_cnt = '0;
          len_on = 1'b0;
          len_cnt = '0;
          r.dac_write = 1'b1;
          r.dac_value = '0;
        end
      end
      if (sched_on) begin
        sched_cnt = sched_cnt + 26'd1;
        if (sched_cnt >= cfg_period) begin
          sched_cnt = '0;
          play_len = (cfg_seq_len > SEQ_DEPTH) ? 11'(SEQ_DEPTH) : cfg_seq_len;
          if (next_idx >= play_len) begin
            sched_on = 1'b0;
          end else if (!tone_on && !len_on) begin
            v = seq_store[next_idx[9:0]];
            tone_lim = 16'(calc_limit(26'(cfg_tone_max), 26'(cfg_tone_min), v, 8'd1,
                                      26'hFFFF));
            len_lim = calc_limit(cfg_len_max, cfg_len_min, v, cfg_len_div, MASK26);
            next_idx = next_idx + 11'd1;
            if (next_idx >= play_len) sched_on = 1'b0;
            tone_cnt = '0;
            tone_on = 1'b1;
            len_cnt = '0;
            len_on = 1'b1;
            r.note_started = 1'b1;
          end
        end
      end
    end
    r.note_sounding = tone_on;
    r.sequence_done = !sched_on;
    return r;
  endfunction

  task automatic send_item(input opcode_e op, input bit [9:0] idx, input bit [9:0] val);
    pending_dac_q.push_back(tone_step(op, idx, val));
    if (idle_en && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, val, idx};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // a note start reads the next entry, so it is loaded first when still unwritten
  task automatic send_tick();
    if (sched_on && next_idx < SEQ_DEPTH && !seq_written[next_idx[9:0]])
      send_item(OP_LOAD, next_idx[9:0], 10'($urandom_range(0, 1023)));
    send_item(OP_TICK, 10'($urandom), 10'($urandom));
  endtask

  task automatic send_random_item();
    if ($urandom_range(0, 3) == 0)
      send_item(OP_LOAD, 10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
    else
      send_tick();
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_dac_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic program_regs(input bit [25:0] seq_max, input bit [25:0] seq_len,
                              input bit [25:0] period, input bit [25:0] tone_max,
                              input bit [25:0] tone_min, input bit [25:0] len_max,
                              input bit [25:0] len_min, input bit [25:0] len_div);
    bit [25:0] vals [8];
    vals = '{seq_max, seq_len, period, tone_max, tone_min, len_max, len_min, len_div};
    settle();
    for (int i = 0; i < 8; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= reg_idx_e'(i);
      cfg_wdata_i <= vals[i];
      @(posedge clk_i);
      case (reg_idx_e'(i))
        REG_SEQ_MAX:   cfg_seq_max  = vals[i][9:0];
        REG_SEQ_LEN:   cfg_seq_len  = vals[i][10:0];
        REG_SCHED_PER: cfg_period   = vals[i];
        REG_TONE_MAX:  cfg_tone_max = vals[i][15:0];
        REG_TONE_MIN:  cfg_tone_min = vals[i][15:0];
        REG_LEN_MAX:   cfg_len_max  = vals[i];
        REG_LEN_MIN:   cfg_len_min  = vals[i];
        REG_LEN_DIV:   cfg_len_div  = vals[i][7:0];
        default: ;
      endcase
    end
    cfg_we_i <= 1'b0;
  endtask

  // short notes and short periods so that many notes play
  task automatic program_random_regs();
    bit [25:0] seq_max;
    bit [25:0] len_floor;
    bit [25:0] period;
    bit [25:0] len_max;
    bit [25:0] len_div;
    case ($urandom_range(0, 3))
      0:       seq_max = 26'd0;
      1:       seq_max = 26'd1023;
      default: seq_max = 26'($urandom_range(1, 1023));
    endcase
    len_floor = (next_idx + 300 > SEQ_DEPTH) ? 26'(SEQ_DEPTH) : 26'(next_idx + 300);
    case ($urandom_range(0, 19))
      0:       period = MASK26;
      1, 2, 3: period = 26'($urandom_range(20, 60));
      default: period = 26'($urandom_range(0, 6));
    endcase
    len_max = 26'($urandom_range(0, 40));
    len_div = ($urandom_range(0, 5) == 0) ? 26'd255 : 26'($urandom_range(0, 4));
    program_regs(seq_max, 26'($urandom_range(len_floor, 2047)), period,
                 26'($urandom_range(0, 8)), 26'($urandom_range(0, 8)),
                 len_max, 26'($urandom_range(0, len_max)), len_div);
  endtask

  task automatic test_reset_state();
    send_item(OP_LOAD, 10'd0, 10'd0);
    send_item(OP_LOAD, 10'd1023, 10'd1023);
    send_item(OP_LOAD, 10'h155, 10'h2AA);
    send_item(OP_LOAD, 10'h2AA, 10'h155);
    repeat (3) send_tick();
  endtask

  task automatic test_register_extremes();
    program_regs(26'd1023, 26'd2047, MASK26, 26'hFFFF, 26'hFFFF, MASK26, MASK26, 26'd255);
    repeat (3) send_tick();
    // zero maximum, divisor and period; every threshold clamps to one
    program_regs(26'd0, 26'd1024, 26'd0, 26'd0, 26'd0, 26'd0, 26'd0, 26'd0);
    repeat (6) send_tick();
  endtask

  task automatic test_threshold_corners();
    // tone minimum above maximum, negative length numerator, then tone step and
    // note end on the same tick
    program_regs(26'd10, 26'd1024, 26'd0, 26'd2, 26'd9, 26'd20, 26'd0, 26'd1);
    send_item(OP_LOAD, next_idx[9:0], 10'd1023);
    send_item(OP_LOAD, 10'(next_idx + 1), 10'd7);
    repeat (8) send_tick();
  endtask

  task automatic test_random_playback();
    for (int ph = 0; ph < 18; ph++) begin
      idle_en = ($urandom_range(0, 3) != 0);
      program_random_regs();
      repeat (95) send_random_item();
    end
  endtask

  task automatic test_final_playback();
    bit stop_on_last;
    int guard;
    idle_en = 1'b0;
    program_random_regs();
    repeat (150) send_random_item();
    // saturated tone and length thresholds, then the sequence runs out
    stop_on_last = $urandom_range(0, 1);
    program_regs(26'd1, stop_on_last ? 26'(next_idx + 1) : 26'd2047, 26'd3, 26'd1, 26'hFFFF,
                 26'd1, MASK26, 26'd1);
    send_item(OP_LOAD, next_idx[9:0], 10'd1023);
    guard = 0;
    while (!(len_on && len_lim == MASK26) && guard < 200) begin
      send_tick();
      guard++;
    end
    program_regs(26'd1, 26'd1, 26'd3, 26'd1, 26'hFFFF, 26'd1, MASK26, 26'd1);
    repeat (20) send_tick();
  endtask

  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 2);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    dac_result_t want;
    dac_result_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{dac_write: m_axis_tuser[0], dac_value: m_axis_tdata[9:0],
              note_started: m_axis_tuser[1], note_sounding: m_axis_tuser[2],
              sequence_done: m_axis_tuser[3]};
      if (pending_dac_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected dac item: w%0d v%0d s%0d n%0d d%0d", got.dac_write,
                   got.dac_value, got.note_started, got.note_sounding, got.sequence_done);
      end else begin
        want = pending_dac_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("dac item mismatch: expected w%0d v%0d s%0d n%0d d%0d, got w%0d v%0d s%0d n%0d d%0d",
                     want.dac_write, want.dac_value, want.note_started, want.note_sounding,
                     want.sequence_done, got.dac_write, got.dac_value, got.note_started,
                     got.note_sounding, got.sequence_done);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_register_extremes();
    test_threshold_corners();
    test_random_playback();
    test_final_playback();
    settle();
    if (mismatches == 0 && pending_dac_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
